FILE: rtl/ctr_pkg.sv
// Package for the config transfer receiver: item and result types, protocol
// codes, the mode encoding and the reflected CRC-32 byte step.
// No dependencies.
package ctr_pkg;

   localparam int unsigned MAX_PAYLOAD = 4096;
   localparam logic [4:0] FIXED_PACKET_BYTES = 5'd26;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   localparam logic [7:0] START_FIXED_A = 8'hAB;
   localparam logic [7:0] START_FIXED_B = 8'hAE;
   localparam logic [7:0] START_SET = 8'hB0;
   localparam logic [7:0] START_GET = 8'hB1;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic CSR_MAX_LENGTH = 1'b0;
   localparam logic CSR_TIMEOUT_MS = 1'b1;

   localparam logic [12:0] MAX_LENGTH_RESET = 13'd4096;
   localparam logic [15:0] TIMEOUT_MS_RESET = 16'd1000;

   localparam logic [2:0] ROUTE_TEXT = 3'd0;
   localparam logic [2:0] ROUTE_FIXED = 3'd1;
   localparam logic [2:0] ROUTE_HEADER = 3'd2;
   localparam logic [2:0] ROUTE_PAYLOAD = 3'd3;
   localparam logic [2:0] ROUTE_GET = 3'd4;
   localparam logic [2:0] ROUTE_TICK = 3'd5;

   localparam logic [2:0] REPLY_NONE = 3'd0;
   localparam logic [2:0] REPLY_READY = 3'd1;
   localparam logic [2:0] REPLY_TOO_BIG = 3'd2;
   localparam logic [2:0] REPLY_BAD_STATE = 3'd3;
   localparam logic [2:0] REPLY_CRC_ERROR = 3'd4;
   localparam logic [2:0] REPLY_TIMEOUT = 3'd5;
   localparam logic [2:0] REPLY_COMMIT = 3'd6;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_FIXED   = 4'b0010,
      MODE_HEADER  = 4'b0100,
      MODE_PAYLOAD = 4'b1000
   } mode_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
      logic       machine_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  route;
      logic [2:0]  reply;
      logic        stage_write;
      logic [11:0] stage_index;
      logic [7:0]  stage_byte;
      logic [12:0] commit_length;
      logic [31:0] commit_crc;
   } rsp_type;

   typedef struct packed {
      logic [12:0] max_length;
      logic [15:0] timeout_ms;
   } cfg_type;

   // One byte of a reflected CRC-32, eight shift steps unrolled.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

FILE: rtl/ctr_csr.sv
// Configuration registers of the config transfer receiver: length limit and
// inactivity timeout. Depends on ctr_pkg.
module ctr_csr
   import ctr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   output cfg_type     cfg
);

   logic [12:0] max_length_ff, max_length_in;
   logic [15:0] timeout_ms_ff, timeout_ms_in;

   always_comb begin
      max_length_in = max_length_ff;
      timeout_ms_in = timeout_ms_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_LENGTH: max_length_in = csr_data[12:0];
            CSR_TIMEOUT_MS: timeout_ms_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
         timeout_ms_ff <= TIMEOUT_MS_RESET;
      end else begin
         max_length_ff <= max_length_in;
         timeout_ms_ff <= timeout_ms_in;
      end
   end

   assign cfg.max_length = max_length_ff;
   assign cfg.timeout_ms = timeout_ms_ff;

endmodule

FILE: rtl/ctr_engine.sv
// Receive state of the config transfer receiver and the combinational logic
// that turns one item into one result. Depends on ctr_pkg.
module ctr_engine
   import ctr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   mode_type    mode_ff, mode_in;
   logic [4:0]  fixed_count_ff, fixed_count_in;
   logic [63:0] header_bytes_ff, header_bytes_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic [12:0] payload_length_ff, payload_length_in;
   logic [31:0] declared_crc_ff, declared_crc_in;
   logic [31:0] running_crc_ff, running_crc_in;
   logic [12:0] payload_count_ff, payload_count_in;
   logic [15:0] idle_ms_ff, idle_ms_in;

   logic [63:0] header_word;
   logic [31:0] header_len;
   logic        len_bad;

   always_comb begin
      header_word = header_bytes_ff;
      header_word[header_count_ff[2:0] * 8 +: 8] =
         header_bytes_ff[header_count_ff[2:0] * 8 +: 8] | item.rx_byte;
      header_len = header_word[31:0];
      len_bad = (header_len == 32'd0) || (header_len > {19'd0, cfg.max_length}) ||
                (header_len > 32'(MAX_PAYLOAD));
   end

   always_comb begin
      mode_in           = mode_ff;
      fixed_count_in    = fixed_count_ff;
      header_bytes_in   = header_bytes_ff;
      header_count_in   = header_count_ff;
      payload_length_in = payload_length_ff;
      declared_crc_in   = declared_crc_ff;
      running_crc_in    = running_crc_ff;
      payload_count_in  = payload_count_ff;
      idle_ms_in        = idle_ms_ff;
      result            = '0;
      result.route      = ROUTE_TEXT;
      result.reply      = REPLY_NONE;

      if (item.action == ACTION_TICK) begin
         result.route = ROUTE_TICK;
         if (mode_ff == MODE_HEADER || mode_ff == MODE_PAYLOAD) begin
            if (idle_ms_ff >= cfg.timeout_ms) begin
               result.reply = REPLY_TIMEOUT;
               mode_in      = MODE_IDLE;
            end else begin
               idle_ms_in = idle_ms_ff + 16'd1;
            end
         end
      end else begin
         unique case (mode_ff)
            MODE_FIXED: begin
               result.route   = ROUTE_FIXED;
               fixed_count_in = fixed_count_ff + 5'd1;
               if (fixed_count_in >= FIXED_PACKET_BYTES) begin
                  mode_in        = MODE_IDLE;
                  fixed_count_in = 5'd0;
               end
            end
            MODE_HEADER: begin
               result.route    = ROUTE_HEADER;
               idle_ms_in      = 16'd0;
               header_bytes_in = header_word;
               header_count_in = header_count_ff + 4'd1;
               if (header_count_in >= 4'd8) begin
                  declared_crc_in = header_word[63:32];
                  header_count_in = 4'd0;
                  // The length check wins over the machine state check.
                  if (len_bad) begin
                     result.reply = REPLY_TOO_BIG;
                     mode_in      = MODE_IDLE;
                  end else if (!item.machine_ok) begin
                     result.reply = REPLY_BAD_STATE;
                     mode_in      = MODE_IDLE;
                  end else begin
                     payload_length_in = header_len[12:0];
                     payload_count_in  = 13'd0;
                     running_crc_in    = CRC_INIT;
                     result.reply      = REPLY_READY;
                     mode_in           = MODE_PAYLOAD;
                  end
               end
            end
            MODE_PAYLOAD: begin
               result.route       = ROUTE_PAYLOAD;
               idle_ms_in         = 16'd0;
               result.stage_write = 1'b1;
               result.stage_index = payload_count_ff[11:0];
               result.stage_byte  = item.rx_byte;
               running_crc_in     = crc_byte(running_crc_ff, item.rx_byte);
               payload_count_in   = payload_count_ff + 13'd1;
               if (payload_count_in >= payload_length_ff) begin
                  mode_in = MODE_IDLE;
                  if (~running_crc_in != declared_crc_ff) begin
                     result.reply = REPLY_CRC_ERROR;
                  end else begin
                     result.reply         = REPLY_COMMIT;
                     result.commit_length = payload_length_ff;
                     result.commit_crc    = declared_crc_ff;
                  end
               end
            end
            default: begin
               // Idle: the byte opens a receiver, is a get or passes as text.
               priority if (item.rx_byte == START_FIXED_A || item.rx_byte == START_FIXED_B) begin
                  result.route   = ROUTE_FIXED;
                  fixed_count_in = 5'd1;
                  mode_in        = MODE_FIXED;
               end else if (item.rx_byte == START_SET) begin
                  result.route    = ROUTE_HEADER;
                  header_count_in = 4'd0;
                  header_bytes_in = 64'd0;
                  idle_ms_in      = 16'd0;
                  mode_in         = MODE_HEADER;
               end else if (item.rx_byte == START_GET) begin
                  result.route = ROUTE_GET;
               end else begin
                  result.route = ROUTE_TEXT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_IDLE;
         fixed_count_ff    <= 5'd0;
         header_bytes_ff   <= 64'd0;
         header_count_ff   <= 4'd0;
         payload_length_ff <= 13'd0;
         declared_crc_ff   <= 32'd0;
         running_crc_ff    <= CRC_INIT;
         payload_count_ff  <= 13'd0;
         idle_ms_ff        <= 16'd0;
      end else if (advance) begin
         mode_ff           <= mode_in;
         fixed_count_ff    <= fixed_count_in;
         header_bytes_ff   <= header_bytes_in;
         header_count_ff   <= header_count_in;
         payload_length_ff <= payload_length_in;
         declared_crc_ff   <= declared_crc_in;
         running_crc_ff    <= running_crc_in;
         payload_count_ff  <= payload_count_in;
         idle_ms_ff        <= idle_ms_in;
      end
   end

endmodule

FILE: rtl/config_transfer_receiver_core.sv
// Top level of the config transfer receiver: input register, output register,
// configuration registers and the receive engine. Depends on ctr_pkg,
// ctr_csr and ctr_engine.
//
// Each item is a received byte or a millisecond tick and yields exactly one
// result. The block takes one item per clock cycle while rsp_ready keeps the
// output register draining: an item is captured in an input register, the
// whole dispatch, header check and CRC-32 byte update run on the held item,
// and the result lands in an output register that drives rsp_valid. The
// recurrence of the receive state through the unrolled eight-step CRC update
// sets that rate. While a result waits on rsp_ready the input register still
// takes one more item. No clearing pass after reset; configuration writes
// take effect at the next edge and are meant to happen with no items in
// flight.
module config_transfer_receiver_core
   import ctr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_machine_ok,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_route,
   output logic [2:0]  rsp_reply,
   output logic        rsp_stage_write,
   output logic [11:0] rsp_stage_index,
   output logic [7:0]  rsp_stage_byte,
   output logic [12:0] rsp_commit_length,
   output logic [31:0] rsp_commit_crc,

   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;

   logic    advance;
   logic    req_fire;
   cfg_type cfg;
   rsp_type result;

   // The held item moves on when the output register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.action     <= req_action;
         in_item_ff.rx_byte    <= req_rx_byte;
         in_item_ff.machine_ok <= req_machine_ok;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   ctr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   ctr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_route         = out_item_ff.route;
   assign rsp_reply         = out_item_ff.reply;
   assign rsp_stage_write   = out_item_ff.stage_write;
   assign rsp_stage_index   = out_item_ff.stage_index;
   assign rsp_stage_byte    = out_item_ff.stage_byte;
   assign rsp_commit_length = out_item_ff.commit_length;
   assign rsp_commit_crc    = out_item_ff.commit_crc;

endmodule

FILE: verif/config_transfer_receiver_core_tb.sv
// Self-checking testbench for config_transfer_receiver_core: a predictor of the
// byte and tick dispatcher checks every result, under directed and random traffic.
// Depends on ctr_pkg and the RTL of config_transfer_receiver_core.
`timescale 1ns / 100ps

module config_transfer_receiver_core_tb;
   import ctr_pkg::*;

   localparam int CLOCK_PERIOD = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACTION_BYTE;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        req_machine_ok = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_route;
   logic [2:0]  rsp_reply;
   logic        rsp_stage_write;
   logic [11:0] rsp_stage_index;
   logic [7:0]  rsp_stage_byte;
   logic [12:0] rsp_commit_length;
   logic [31:0] rsp_commit_crc;

   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_MAX_LENGTH;
   logic [15:0] csr_data = 16'd0;

   config_transfer_receiver_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_rx_byte       (req_rx_byte),
      .req_machine_ok    (req_machine_ok),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_route         (rsp_route),
      .rsp_reply         (rsp_reply),
      .rsp_stage_write   (rsp_stage_write),
      .rsp_stage_index   (rsp_stage_index),
      .rsp_stage_byte    (rsp_stage_byte),
      .rsp_commit_length (rsp_commit_length),
      .rsp_commit_crc    (rsp_commit_crc),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // Receiver state as the predictor sees it, plus its copy of the registers.
   mode_type    rx_mode = MODE_IDLE;
   logic [4:0]  fixed_count = '0;
   logic [63:0] header_shift = '0;
   logic [3:0]  header_count = '0;
   logic [12:0] payload_length = '0;
   logic [31:0] declared_crc = '0;
   logic [31:0] running_crc = CRC_INIT;
   logic [12:0] payload_count = '0;
   logic [15:0] idle_ticks = '0;
   logic [12:0] length_limit = MAX_LENGTH_RESET;
   logic [15:0] tick_limit = TIMEOUT_MS_RESET;

   rsp_type     pending_replies[$];
   int          items_sent = 0;
   int          results_checked = 0;
   int          mismatch_count = 0;
   int          reply_tally[8] = '{default: 0};
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;

   // Reflected CRC-32, one input bit per step, least significant bit first.
   function automatic logic [31:0] fold_crc_byte(input logic [31:0] crc,
                                                 input logic [7:0] data);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ data[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Advances the predicted receiver by one item and returns the result it gives.
   function automatic rsp_type advance_receiver(input logic action, input logic [7:0] data,
                                                input logic ok);
      rsp_type     r;
      logic [31:0] len;
      r = '0;
      if (action == ACTION_TICK) begin
         r.route = ROUTE_TICK;
         if (rx_mode == MODE_HEADER || rx_mode == MODE_PAYLOAD) begin
            if (idle_ticks >= tick_limit) begin
               r.reply = REPLY_TIMEOUT;
               rx_mode = MODE_IDLE;
            end else begin
               idle_ticks = idle_ticks + 16'd1;
            end
         end
      end else begin
         case (rx_mode)
            MODE_FIXED: begin
               r.route = ROUTE_FIXED;
               fixed_count = fixed_count + 5'd1;
               if (fixed_count >= FIXED_PACKET_BYTES) begin
                  rx_mode = MODE_IDLE;
                  fixed_count = '0;
               end
            end
            MODE_HEADER: begin
               r.route = ROUTE_HEADER;
               idle_ticks = '0;
               header_shift[header_count[2:0] * 8 +: 8] =
                  header_shift[header_count[2:0] * 8 +: 8] | data;
               header_count = header_count + 4'd1;
               if (header_count >= 4'd8) begin
                  len = header_shift[31:0];
                  declared_crc = header_shift[63:32];
                  header_count = '0;
                  // The length test wins over the machine state test.
                  if (len == 0 || len > length_limit || len > MAX_PAYLOAD) begin
                     r.reply = REPLY_TOO_BIG;
                     rx_mode = MODE_IDLE;
                  end else if (!ok) begin
                     r.reply = REPLY_BAD_STATE;
                     rx_mode = MODE_IDLE;
                  end else begin
                     payload_length = len[12:0];
                     payload_count = '0;
                     running_crc = CRC_INIT;
                     r.reply = REPLY_READY;
                     rx_mode = MODE_PAYLOAD;
                  end
               end
            end
            MODE_PAYLOAD: begin
               r.route = ROUTE_PAYLOAD;
               idle_ticks = '0;
               r.stage_write = 1'b1;
               r.stage_index = payload_count[11:0];
               r.stage_byte = data;
               running_crc = fold_crc_byte(running_crc, data);
               payload_count = payload_count + 13'd1;
               if (payload_count >= payload_length) begin
                  rx_mode = MODE_IDLE;
                  if (~running_crc != declared_crc) begin
                     r.reply = REPLY_CRC_ERROR;
                  end else begin
                     r.reply = REPLY_COMMIT;
                     r.commit_length = payload_length;
                     r.commit_crc = declared_crc;
                  end
               end
            end
            default: begin
               if (data == START_FIXED_A || data == START_FIXED_B) begin
                  r.route = ROUTE_FIXED;
                  fixed_count = 5'd1;
                  rx_mode = MODE_FIXED;
               end else if (data == START_SET) begin
                  r.route = ROUTE_HEADER;
                  header_count = '0;
                  header_shift = '0;
                  idle_ticks = '0;
                  rx_mode = MODE_HEADER;
               end else if (data == START_GET) begin
                  r.route = ROUTE_GET;
               end else begin
                  r.route = ROUTE_TEXT;
               end
            end
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 40) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                   results_checked, name, got, want));
      end
   endtask

   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected result, route %0d reply %0d",
                                      rsp_route, rsp_reply));
         end else begin
            want = pending_replies.pop_front();
            reply_tally[want.reply]++;
            check_field("route", 32'(rsp_route), 32'(want.route));
            check_field("reply", 32'(rsp_reply), 32'(want.reply));
            check_field("stage_write", 32'(rsp_stage_write), 32'(want.stage_write));
            check_field("stage_index", 32'(rsp_stage_index), 32'(want.stage_index));
            check_field("stage_byte", 32'(rsp_stage_byte), 32'(want.stage_byte));
            check_field("commit_length", 32'(rsp_commit_length),
                        32'(want.commit_length));
            check_field("commit_crc", rsp_commit_crc, want.commit_crc);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic send_item(input logic action, input logic [7:0] data, input logic ok);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_rx_byte <= data;
      req_machine_ok <= ok;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_replies.push_back(advance_receiver(action, data, ok));
      items_sent++;
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_item(ACTION_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   task automatic await_all_results();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input logic [15:0] value);
      await_all_results();
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_MAX_LENGTH) begin
         length_limit = value[12:0];
      end else begin
         tick_limit = value;
      end
   endtask

   // Start byte, 8 header bytes and n_payload random payload bytes. The declared
   // CRC matches the payload unless bad_crc is set; ok goes with the last header byte.
   task automatic send_transfer(input logic [31:0] len_field, input int unsigned n_payload,
                                input logic bad_crc, input logic ok);
      logic [7:0]  payload[$];
      logic [7:0]  data;
      logic [31:0] crc;
      logic [63:0] header;
      crc = CRC_INIT;
      repeat (n_payload) begin
         data = 8'($urandom_range(255));
         payload.push_back(data);
         crc = fold_crc_byte(crc, data);
      end
      crc = ~crc;
      if (bad_crc) begin
         crc = crc ^ (32'd1 << $urandom_range(31));
      end
      header = {crc, len_field};
      send_item(ACTION_BYTE, START_SET, 1'($urandom_range(1)));
      for (int i = 0; i < 8; i++) begin
         send_item(ACTION_BYTE, header[i * 8 +: 8], (i == 7) ? ok : 1'($urandom_range(1)));
      end
      foreach (payload[k]) begin
         send_item(ACTION_BYTE, payload[k], 1'($urandom_range(1)));
      end
   endtask

   task automatic send_fixed_packet(input logic [7:0] start, input int tick_pct);
      send_item(ACTION_BYTE, start, 1'($urandom_range(1)));
      for (int i = 1; i < FIXED_PACKET_BYTES; i++) begin
         if ($urandom_range(99) < tick_pct) begin
            send_ticks(1);
         end
         send_item(ACTION_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   // Mostly short lengths, now and then up to a few hundred bytes.
   function automatic logic [31:0] pick_length();
      int unsigned cap;
      cap = (length_limit > MAX_PAYLOAD) ? MAX_PAYLOAD : length_limit;
      if (cap == 0) begin
         return 32'd1;
      end
      if ($urandom_range(99) < 85) begin
         return $urandom_range(1, (cap < 16) ? cap : 16);
      end
      return $urandom_range(1, (cap < 300) ? cap : 300);
   endfunction

   task automatic send_random_frame();
      int unsigned kind;
      logic [31:0] len;
      kind = $urandom_range(99);
      len = pick_length();
      if (kind < 45) begin
         send_transfer(len, len, 1'b0, 1'b1);
      end else if (kind < 52) begin
         send_transfer(len, len, 1'b1, 1'b1);
      end else if (kind < 57) begin
         send_transfer(len, 0, 1'b0, 1'b0);
      end else if (kind < 63) begin
         case ($urandom_range(3))
            0: len = 32'd0;
            1: len = length_limit + 32'd1;
            2: len = MAX_PAYLOAD + 1;
            default: len = $urandom;
         endcase
         send_transfer(len, 0, 1'b0, 1'($urandom_range(1)));
      end else if (kind < 68) begin
         // An abandoned transfer is only cleared by ticks, so keep this to short timeouts.
         if (tick_limit <= 8) begin
            if ($urandom_range(1)) begin
               send_transfer(len, $urandom_range(0, len - 1), 1'b0, 1'b1);
            end else begin
               send_item(ACTION_BYTE, START_SET, 1'($urandom_range(1)));
               repeat ($urandom_range(0, 7)) begin
                  send_item(ACTION_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
               end
            end
            send_ticks(tick_limit + $urandom_range(1, 2));
         end else begin
            send_ticks(1);
         end
      end else if (kind < 78) begin
         send_fixed_packet($urandom_range(1) ? START_FIXED_A : START_FIXED_B, 5);
      end else if (kind < 84) begin
         send_item(ACTION_BYTE, START_GET, 1'($urandom_range(1)));
      end else if (kind < 92) begin
         send_ticks($urandom_range(1, 3));
      end else begin
         repeat ($urandom_range(1, 4)) begin
            send_item(ACTION_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic test_dispatch_basics();
      send_item(ACTION_BYTE, 8'h00, 1'b0);
      send_item(ACTION_BYTE, 8'hFF, 1'b1);
      send_item(ACTION_BYTE, START_GET, 1'b0);
      send_ticks(2);
      send_transfer(32'd1, 1, 1'b0, 1'b1);
      send_transfer(32'd0, 0, 1'b0, 1'b1);
   endtask

   task automatic test_header_checks();
      // Too long and a busy machine at once: only the length is reported.
      send_transfer(32'd5000, 0, 1'b0, 1'b0);
      send_transfer(32'd3, 0, 1'b0, 1'b0);
      // After a rejected header the stream is dispatched from idle again.
      send_item(ACTION_BYTE, START_GET, 1'b1);
      send_item(ACTION_BYTE, 8'h42, 1'b1);
      send_transfer(32'd6, 6, 1'b1, 1'b1);
      send_transfer(32'd2, 2, 1'b0, 1'b1);
   endtask

   task automatic test_fixed_packets();
      send_fixed_packet(START_FIXED_A, 20);
      send_item(ACTION_BYTE, START_GET, 1'b0);
      send_fixed_packet(START_FIXED_B, 0);
      send_ticks(1);
      send_item(ACTION_BYTE, START_SET, 1'b1);
      send_ticks(1);
      send_transfer(32'd0, 0, 1'b0, 1'b1);
   endtask

   task automatic test_inactivity_timeout();
      sender_idle_pct = 29;
      receiver_stall_pct = 29;
      write_register(CSR_TIMEOUT_MS, 16'd2);
      send_item(ACTION_BYTE, START_SET, 1'b1);
      repeat (3) send_item(ACTION_BYTE, 8'($urandom_range(255)), 1'b1);
      send_ticks(2);
      // A header byte restarts the count, so the third tick after it aborts.
      send_item(ACTION_BYTE, 8'($urandom_range(255)), 1'b1);
      send_ticks(3);
      send_item(ACTION_BYTE, START_GET, 1'b1);
      send_transfer(32'd4, 2, 1'b0, 1'b1);
      send_ticks(4);
      send_item(ACTION_BYTE, START_GET, 1'b1);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
   endtask

   task automatic test_limit_registers();
      write_register(CSR_MAX_LENGTH, 16'd0);
      write_register(CSR_TIMEOUT_MS, 16'd0);
      send_transfer(32'd1, 0, 1'b0, 1'b1);
      write_register(CSR_MAX_LENGTH, 16'd1);
      // With no ticks allowed the first tick aborts an open transfer.
      send_transfer(32'd1, 0, 1'b0, 1'b1);
      send_ticks(2);
      send_transfer(32'd2, 0, 1'b0, 1'b1);
      send_transfer(32'd1, 1, 1'b0, 1'b1);
      write_register(CSR_MAX_LENGTH, 16'h1FFF);
      write_register(CSR_TIMEOUT_MS, 16'hFFFF);
      send_transfer(MAX_PAYLOAD, 0, 1'b0, 1'b0);
      send_transfer(MAX_PAYLOAD + 1, 0, 1'b0, 1'b1);
      send_transfer(32'h0100_0001, 0, 1'b0, 1'b1);
      send_transfer(32'd3, 3, 1'b0, 1'b1);
   endtask

   // The largest length is accepted; the transfer is cut short and then timed out.
   task automatic test_largest_transfer();
      write_register(CSR_MAX_LENGTH, 16'(MAX_LENGTH_RESET));
      write_register(CSR_TIMEOUT_MS, 16'd2);
      send_transfer(MAX_PAYLOAD, 40, 1'b0, 1'b1);
      send_ticks(3);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [12:0] max_len,
                                      input logic [15:0] timeout,
                                      input int item_count);
      int first_item;
      write_register(CSR_MAX_LENGTH, 16'(max_len));
      write_register(CSR_TIMEOUT_MS, timeout);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      first_item = items_sent;
      while (items_sent - first_item < item_count) begin
         send_random_frame();
         // Now and then hold off until the block has drained completely.
         if ($urandom_range(99) < 3) begin
            await_all_results();
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_dispatch_basics();
      test_header_checks();
      test_fixed_packets();
      test_inactivity_timeout();
      test_limit_registers();
      test_largest_transfer();
      test_random_traffic(0, 0, 13'd4096, 16'd2, 250);
      test_random_traffic(67, 0, 13'd1, 16'd1, 250);
      test_random_traffic(0, 67, 13'h1FFF, 16'hFFFF, 250);
      test_random_traffic(29, 29, 13'd37, 16'd5, 250);
      await_all_results();
      repeat (8) @(posedge clock);
      $display("Run covered %0d items and %0d results, %0d mismatches.",
               items_sent, results_checked, mismatch_count);
      $display("Commits %0d, CRC errors %0d, timeouts %0d, rejected headers %0d.",
               reply_tally[REPLY_COMMIT], reply_tally[REPLY_CRC_ERROR],
               reply_tally[REPLY_TIMEOUT],
               reply_tally[REPLY_TOO_BIG] + reply_tally[REPLY_BAD_STATE]);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(CLOCK_PERIOD * 500_000);
      $display("Run timed out with %0d results still expected.", pending_replies.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
rtl/ctr_pkg.sv
rtl/ctr_csr.sv
rtl/ctr_engine.sv
rtl/config_transfer_receiver_core.sv
verif/config_transfer_receiver_core_tb.sv
